@@ hw/rtl/aiff_stream_parser_unit_macros.svh @@
// Assertion macros for the AIFF stream parser.
// No dependencies; included by modules that carry assertions.
`ifndef AIFF_STREAM_PARSER_UNIT_MACROS_SVH
`define AIFF_STREAM_PARSER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define ASP_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASP_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define ASP_ASSERT_IMPL(label, clk, rst_n, prop)
`define ASP_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ hw/rtl/asp_pkg.sv @@
// Package for the AIFF stream parser: parse phases, tags, result codes.
// No dependencies.
package asp_pkg;
  localparam int MAX_SAMPLE_BITS = 32;
  localparam logic [31:0] TAG_FORM = 32'h464F524D;
  localparam logic [31:0] TAG_AIFF = 32'h41494646;
  localparam logic [31:0] TAG_COMM = 32'h434F4D4D;
  localparam logic [31:0] TAG_SSND = 32'h53534E44;
  localparam logic [32:0] COMM_MIN_SIZE = 33'd18;
  localparam logic [14:0] EXP_BIAS = 15'd16382;

  typedef enum logic [4:0] {
    P_FORM, P_FSIZE, P_AIFF, P_CKID, P_CKSIZE, P_CHANS, P_FRAMES, P_DEPTH,
    P_EXP, P_MANT, P_SKIP, P_PAD, P_SOFF, P_SBLK, P_SLEAD, P_SDATA, P_DEAD
  } phase_t;

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0, KIND_SAMPLE = 2'd1, KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BAD_TAGS = 3'd1, ST_SHORT_COMM = 3'd2,
    ST_NO_COMM = 3'd3, ST_MISMATCH = 3'd4
  } status_t;

  // One result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] channel_count;
    logic [31:0] frame_count;
    logic [15:0] sample_bits;
    logic [31:0] rate_hz;
    logic        rate_clamped;
    logic [15:0] channel_index;
    logic [31:0] sample_value;
    logic        frame_end;
    logic [2:0]  status;
  } result_t;

  localparam int RES_W = $bits(result_t);
endpackage

@@ hw/rtl/aiff_stream_parser_unit.sv @@
// AIFF stream parser top level. Latency: a result is on the output the cycle
// after its byte is accepted. Throughput: one byte per cycle while each byte
// yields at most one result and the output is ready; a byte that yields two
// results (sample or format plus status at the final byte) holds the input
// back, and the input also waits while the two-entry result queue cannot
// take a byte's results. Reset (rst_n low, synchronous) clears all parser state
// and empties the result queue.
// Depends on asp_pkg, asp_rate and the assertion macros header.
`include "aiff_stream_parser_unit_macros.svh"
module aiff_stream_parser_unit import asp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tuser,   // first_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [15:0] channel_count, [47:16] frame_count, [63:48] sample_bits,
  // [95:64] rate_hz, [96] rate_clamped, [112:97] channel_index,
  // [144:113] sample_value, [145] frame_end, [148:146] status, [151:149] zero
  output logic [151:0] out_tdata,
  output logic [1:0]   out_tuser   // kind
);
  // parser state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  bif_r, bif_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [32:0] left_r, left_nxt;
  logic        pad_r, pad_nxt;
  logic [15:0] chans_r, chans_nxt;
  logic [31:0] fcl_r, fcl_nxt;
  logic [15:0] depth_r, depth_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [63:0] mant_r, mant_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [15:0] cc_r, cc_nxt;
  logic [31:0] fseen_r, fseen_nxt;
  logic        hf_r, hf_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [2:0]  nb_r, nb_nxt;   // bytes per sample

  // two-entry result queue
  result_t     q_r [2];
  result_t     q0_nxt, q1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  result_t     r0, r1;
  logic [1:0]  nres;
  logic        acc_in, pop;

  logic [31:0] rate;
  logic        clamped;

  // rate from the mantissa as it stands with the byte on the input
  asp_rate u_rate (.exponent_word(exp_r), .mantissa({mant_r[55:0], in_tdata}),
                   .rate_hz(rate), .rate_clamped(clamped));

  assign pop = out_tvalid && out_tready;
  // need room for up to two results after this cycle's pop
  assign in_tready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);
  assign acc_in = in_tvalid && in_tready;

  // byte parser
  always_comb begin
    logic [7:0]  b;
    logic [31:0] tg;
    logic [32:0] cl;
    logic [31:0] top, v;
    logic [5:0]  lsh;
    logic [2:0]  st;
    result_t     rs, rz;
    logic [1:0]  n;
    b = in_tdata;
    tg = '0;
    cl = '0;
    top = '0;
    v = '0;
    lsh = '0;
    st = '0;
    rz = '0;
    rs = '0;
    n = '0;
    phase_nxt = phase_r; bif_nxt = bif_r; tag_nxt = tag_r; left_nxt = left_r;
    pad_nxt = pad_r; chans_nxt = chans_r; fcl_nxt = fcl_r; depth_nxt = depth_r;
    exp_nxt = exp_r; mant_nxt = mant_r; acc_nxt = acc_r; cc_nxt = cc_r;
    fseen_nxt = fseen_r; hf_nxt = hf_r; err_nxt = err_r; nb_nxt = nb_r;
    r0 = rz;
    r1 = rz;
    if (in_tuser) begin
      phase_nxt = P_FORM; bif_nxt = '0; tag_nxt = '0; left_nxt = '0;
      pad_nxt = 1'b0; chans_nxt = '0; fcl_nxt = '0; depth_nxt = '0;
      exp_nxt = '0; mant_nxt = '0; acc_nxt = '0; cc_nxt = '0; fseen_nxt = '0;
      hf_nxt = 1'b0; err_nxt = '0; nb_nxt = '0;
    end
    case (phase_nxt)
      P_FORM, P_AIFF: begin
        tg = {tag_nxt[23:0], b};
        tag_nxt = tg;
        bif_nxt = bif_nxt + 4'd1;
        if (bif_nxt == 4'd4) begin
          bif_nxt = '0;
          if (tg != ((phase_nxt == P_FORM) ? TAG_FORM : TAG_AIFF)) begin
            if (err_nxt == ST_OK) err_nxt = ST_BAD_TAGS;
            phase_nxt = P_DEAD;
          end else begin
            phase_nxt = (phase_nxt == P_FORM) ? P_FSIZE : P_CKID;
          end
          tag_nxt = '0;
        end
      end
      P_FSIZE: begin
        bif_nxt = bif_nxt + 4'd1;
        if (bif_nxt == 4'd4) begin
          bif_nxt = '0;
          phase_nxt = P_AIFF;
        end
      end
      P_CKID: begin
        tag_nxt = {tag_nxt[23:0], b};
        bif_nxt = bif_nxt + 4'd1;
        if (bif_nxt == 4'd4) begin
          bif_nxt = '0;
          phase_nxt = P_CKSIZE;
          left_nxt = '0;
        end
      end
      P_CKSIZE: begin
        cl = {1'b0, left_nxt[23:0], b};
        left_nxt = cl;
        bif_nxt = bif_nxt + 4'd1;
        if (bif_nxt == 4'd4) begin
          bif_nxt = '0;
          pad_nxt = cl[0];
          if (cl == '0) begin
            acc_nxt = '0;
            phase_nxt = P_CKID;
            pad_nxt = 1'b0;
          end else if (tag_nxt == TAG_COMM) begin
            if (cl < COMM_MIN_SIZE) begin
              if (err_nxt == ST_OK) err_nxt = ST_SHORT_COMM;
              phase_nxt = P_SKIP;
            end else begin
              chans_nxt = '0; fcl_nxt = '0; depth_nxt = '0; exp_nxt = '0;
              mant_nxt = '0; phase_nxt = P_CHANS;
            end
          end else if (tag_nxt == TAG_SSND) begin
            if (!hf_nxt) begin
              if (err_nxt == ST_OK) err_nxt = ST_NO_COMM;
              phase_nxt = P_SKIP;
            end else if (depth_nxt == '0 || depth_nxt > 16'(MAX_SAMPLE_BITS) ||
                         chans_nxt == '0) begin
              phase_nxt = P_SKIP;
            end else begin
              tag_nxt = '0;
              phase_nxt = P_SOFF;
              nb_nxt = 3'(({1'b0, depth_nxt[5:0]} + 7'd7) >> 3);
            end
          end else begin
            phase_nxt = P_SKIP;
          end
        end
      end
      P_PAD: phase_nxt = P_CKID;
      P_DEAD: ;
      default: begin
        // chunk body
        case (phase_nxt)
          P_CHANS: begin
            chans_nxt = {chans_nxt[7:0], b};
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == 4'd2) begin bif_nxt = '0; phase_nxt = P_FRAMES; end
          end
          P_FRAMES: begin
            fcl_nxt = {fcl_nxt[23:0], b};
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == 4'd4) begin bif_nxt = '0; phase_nxt = P_DEPTH; end
          end
          P_DEPTH: begin
            depth_nxt = {depth_nxt[7:0], b};
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == 4'd2) begin bif_nxt = '0; phase_nxt = P_EXP; end
          end
          P_EXP: begin
            exp_nxt = {exp_nxt[7:0], b};
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == 4'd2) begin bif_nxt = '0; phase_nxt = P_MANT; end
          end
          P_MANT: begin
            mant_nxt = {mant_nxt[55:0], b};
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == 4'd8) begin
              bif_nxt = '0;
              hf_nxt = 1'b1;
              phase_nxt = P_SKIP;
              rs = rz;
              rs.kind = KIND_FORMAT;
              rs.channel_count = chans_nxt;
              rs.frame_count = fcl_nxt;
              rs.sample_bits = depth_nxt;
              rs.rate_hz = rate;
              rs.rate_clamped = clamped;
              r0 = rs;
              n = 2'd1;
            end
          end
          P_SOFF: begin
            tag_nxt = {tag_nxt[23:0], b};
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == 4'd4) begin bif_nxt = '0; phase_nxt = P_SBLK; end
          end
          P_SBLK: begin
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == 4'd4) begin
              bif_nxt = '0;
              phase_nxt = (tag_nxt != '0) ? P_SLEAD : P_SDATA;
            end
          end
          P_SLEAD: begin
            tag_nxt = tag_nxt - 32'd1;
            if (tag_nxt == '0) phase_nxt = P_SDATA;
          end
          P_SDATA: begin
            acc_nxt = {acc_nxt[23:0], b};
            bif_nxt = bif_nxt + 4'd1;
            if (bif_nxt == {1'b0, nb_nxt}) begin
              bif_nxt = '0;
              top = acc_nxt << (6'd32 - {nb_nxt, 3'b000});
              lsh = 6'(7'd32 - {1'b0, depth_nxt[5:0]});
              v = $signed(top) >>> lsh;
              rs.kind = KIND_SAMPLE;
              rs.channel_index = cc_nxt;
              rs.sample_value = v;
              if ({1'b0, cc_nxt} + 17'd1 >= {1'b0, chans_nxt}) begin
                rs.frame_end = 1'b1;
                cc_nxt = '0;
                if (fseen_nxt != '1) fseen_nxt = fseen_nxt + 32'd1;
              end else begin
                cc_nxt = cc_nxt + 16'd1;
              end
              acc_nxt = '0;
              r0 = rs;
              n = 2'd1;
            end
          end
          default: ;
        endcase
        left_nxt = left_nxt - 33'd1;
        if (left_nxt == '0) begin
          bif_nxt = '0;
          acc_nxt = '0;
          phase_nxt = pad_nxt ? P_PAD : P_CKID;
          pad_nxt = 1'b0;
        end
      end
    endcase
    // status at the final byte
    if (in_tlast) begin
      st = err_nxt;
      if (phase_nxt == P_FORM || phase_nxt == P_FSIZE || phase_nxt == P_AIFF)
        st = ST_BAD_TAGS;
      else if (st == ST_OK && fseen_nxt != fcl_nxt)
        st = ST_MISMATCH;
      rs = rz;
      rs.kind = KIND_STATUS;
      rs.status = st;
      if (n == 2'd0) r0 = rs;
      else r1 = rs;
      n = n + 2'd1;
      phase_nxt = P_FORM; bif_nxt = '0; tag_nxt = '0; left_nxt = '0;
      pad_nxt = 1'b0; chans_nxt = '0; fcl_nxt = '0; depth_nxt = '0;
      exp_nxt = '0; mant_nxt = '0; acc_nxt = '0; cc_nxt = '0; fseen_nxt = '0;
      hf_nxt = 1'b0; err_nxt = '0; nb_nxt = '0;
    end
    nres = n;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_FORM; bif_r <= '0; tag_r <= '0; left_r <= '0; pad_r <= 1'b0;
      chans_r <= '0; fcl_r <= '0; depth_r <= '0; exp_r <= '0; mant_r <= '0;
      acc_r <= '0; cc_r <= '0; fseen_r <= '0; hf_r <= 1'b0; err_r <= '0;
      nb_r <= '0;
    end else if (acc_in) begin
      phase_r <= phase_nxt; bif_r <= bif_nxt; tag_r <= tag_nxt;
      left_r <= left_nxt; pad_r <= pad_nxt; chans_r <= chans_nxt;
      fcl_r <= fcl_nxt; depth_r <= depth_nxt; exp_r <= exp_nxt;
      mant_r <= mant_nxt; acc_r <= acc_nxt; cc_r <= cc_nxt;
      fseen_r <= fseen_nxt; hf_r <= hf_nxt; err_r <= err_nxt; nb_r <= nb_nxt;
    end
  end

  // result queue: a byte is taken only when the queue is empty after the pop
  always_comb begin
    q0_nxt = q_r[0];
    q1_nxt = q_r[1];
    cnt_nxt = cnt_r;
    if (pop) begin
      q0_nxt = q_r[1];
      cnt_nxt = cnt_r - 2'd1;
    end
    if (acc_in && nres != 2'd0) begin
      q0_nxt = r0;
      q1_nxt = r1;
      cnt_nxt = nres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      q_r[0] <= '0;
      q_r[1] <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      q_r[0] <= q0_nxt;
      q_r[1] <= q1_nxt;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tuser = q_r[0].kind;
  assign out_tdata = {3'd0, q_r[0].status, q_r[0].frame_end, q_r[0].sample_value,
                      q_r[0].channel_index, q_r[0].rate_clamped, q_r[0].rate_hz,
                      q_r[0].sample_bits, q_r[0].frame_count, q_r[0].channel_count};

  `ASP_ASSERT_NEVER(a_q_over, clk, rst_n, cnt_r == 2'd3)
  `ASP_ASSERT_IMPL(a_no_take_full, clk, rst_n, (cnt_r == 2'd2) |-> !in_tready)
  `ASP_ASSERT_IMPL(a_last_resets, clk, rst_n,
                   (acc_in && in_tlast) |=> (phase_r == P_FORM && err_r == ST_OK))
endmodule

@@ hw/rtl/asp_rate.sv @@
// Converts the 80-bit extended COMM rate to a saturated 32-bit integer.
// Depends on asp_pkg.
module asp_rate import asp_pkg::*; (
  input  logic [15:0] exponent_word,
  input  logic [63:0] mantissa,
  output logic [31:0] rate_hz,
  output logic        rate_clamped
);
  logic [14:0] e;
  logic [63:0] v;
  logic [5:0]  sh;

  // integer part = mantissa >> (64 - (e - 16382)), valid for e in 16383..16446
  always_comb begin
    e = exponent_word[14:0];
    sh = 6'(15'd16446 - e);
    v = mantissa >> sh;
    rate_hz = '0;
    rate_clamped = 1'b0;
    if (!exponent_word[15] && e > EXP_BIAS) begin
      if (e > 15'd16446) begin
        if (mantissa != '0) begin
          rate_hz = '1;
          rate_clamped = 1'b1;
        end
      end else if (v[63:32] != '0) begin
        rate_hz = '1;
        rate_clamped = 1'b1;
      end else begin
        rate_hz = v[31:0];
      end
    end
  end
endmodule

@@ tb/aiff_stream_parser_unit_tb.sv @@
// Testbench for aiff_stream_parser_unit: streams generated AIFF files in, predicts
// format, sample and status results, and checks them field by field in order.
// Depends on asp_pkg and the aiff_stream_parser_unit RTL.
`timescale 1ns / 1ps
module aiff_stream_parser_unit_tb;
  import asp_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [151:0] out_tdata;
  logic [1:0]   out_tuser;

  aiff_stream_parser_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       hold;   // wait until all results are back before sending
  } byte_req_t;

  typedef struct {
    kind_t        kind;
    logic [151:0] data;
  } result_exp_t;

  byte_req_t   pending_bytes[$];
  result_exp_t expected_results[$];
  logic [7:0]  file_bytes[$];

  int errors;
  int reported;
  int watchdog;
  bit done_gen;

  // Parser state mirror
  phase_t      ph;
  int          bif;
  logic [31:0] tag;
  logic [32:0] left;
  logic        pad_pend;
  logic [15:0] chans;
  logic [31:0] frames_claimed;
  logic [15:0] depth;
  logic [15:0] exp_word;
  logic [63:0] mant;
  logic [31:0] acc;
  logic [15:0] chan_cnt;
  logic [31:0] frames_seen;
  logic        have_fmt;
  logic [2:0]  err_code;

  // Field table of out_tdata, lowest first; last entry is the zero fill
  localparam int FLD_N = 10;
  localparam int FLD_LO[FLD_N] = '{0, 16, 48, 64, 96, 97, 113, 145, 146, 149};
  localparam int FLD_W[FLD_N]  = '{16, 32, 16, 32, 1, 16, 32, 1, 3, 3};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void parser_clear();
    ph = P_FORM; bif = 0; tag = '0; left = '0; pad_pend = 1'b0; chans = '0;
    frames_claimed = '0; depth = '0; exp_word = '0; mant = '0; acc = '0;
    chan_cnt = '0; frames_seen = '0; have_fmt = 1'b0; err_code = ST_OK;
  endfunction

  function automatic void record_error(status_t code);
    if (err_code == ST_OK) err_code = code;
  endfunction

  function automatic bit field_complete(int len);
    bif++;
    if (bif >= len) begin
      bif = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void push_result(kind_t k, logic [151:0] d);
    result_exp_t r;
    r.kind = k;
    r.data = d;
    expected_results.push_back(r);
  endfunction

  // Integer part of the 80-bit extended rate, saturated to 32 bits
  function automatic logic [32:0] rate_integer();
    int sh;
    logic [63:0] v;
    if (exp_word[15]) return '0;
    sh = 64 - (int'(exp_word[14:0]) - int'(EXP_BIAS));
    if (sh >= 64) return '0;
    if (sh < 0) return (mant != 0) ? {1'b1, 32'hFFFF_FFFF} : '0;
    v = mant >> sh;
    if (v > 64'hFFFF_FFFF) return {1'b1, 32'hFFFF_FFFF};
    return {1'b0, v[31:0]};
  endfunction

  function automatic void sample_out();
    int nb;
    logic [31:0] top;
    logic [31:0] v;
    logic [151:0] d;
    nb = (int'(depth) + 7) / 8;
    top = acc << (32 - 8 * nb);
    v = top >> (32 - int'(depth));
    if (depth < 32 && v[depth - 1]) v = v | (32'hFFFF_FFFF << depth);
    d = '0;
    d[112:97] = chan_cnt;
    d[144:113] = v;
    if (32'(chan_cnt) + 1 >= 32'(chans)) begin
      d[145] = 1'b1;
      chan_cnt = '0;
      if (frames_seen != 32'hFFFF_FFFF) frames_seen++;
    end else begin
      chan_cnt++;
    end
    push_result(KIND_SAMPLE, d);
    acc = '0;
  endfunction

  function automatic void chunk_done();
    bif = 0;
    acc = '0;
    ph = pad_pend ? P_PAD : P_CKID;
    pad_pend = 1'b0;
  endfunction

  function automatic void chunk_start();
    bif = 0;
    if (tag == TAG_COMM) begin
      if (left < COMM_MIN_SIZE) begin
        record_error(ST_SHORT_COMM);
        ph = P_SKIP;
      end else begin
        chans = '0; frames_claimed = '0; depth = '0; exp_word = '0; mant = '0;
        ph = P_CHANS;
      end
    end else if (tag == TAG_SSND) begin
      if (!have_fmt) begin
        record_error(ST_NO_COMM);
        ph = P_SKIP;
      end else if (depth < 1 || depth > MAX_SAMPLE_BITS || chans == 0) begin
        ph = P_SKIP;
      end else begin
        tag = '0;
        ph = P_SOFF;
      end
    end else begin
      ph = P_SKIP;
    end
  endfunction

  function automatic void chunk_body(logic [7:0] b);
    logic [32:0] rt;
    logic [151:0] d;
    case (ph)
      P_CHANS: begin
        chans = {chans[7:0], b};
        if (field_complete(2)) ph = P_FRAMES;
      end
      P_FRAMES: begin
        frames_claimed = {frames_claimed[23:0], b};
        if (field_complete(4)) ph = P_DEPTH;
      end
      P_DEPTH: begin
        depth = {depth[7:0], b};
        if (field_complete(2)) ph = P_EXP;
      end
      P_EXP: begin
        exp_word = {exp_word[7:0], b};
        if (field_complete(2)) ph = P_MANT;
      end
      P_MANT: begin
        mant = {mant[55:0], b};
        if (field_complete(8)) begin
          have_fmt = 1'b1;
          rt = rate_integer();
          d = '0;
          d[15:0] = chans;
          d[47:16] = frames_claimed;
          d[63:48] = depth;
          d[95:64] = rt[31:0];
          d[96] = rt[32];
          push_result(KIND_FORMAT, d);
          ph = P_SKIP;
        end
      end
      P_SOFF: begin
        tag = {tag[23:0], b};
        if (field_complete(4)) ph = P_SBLK;
      end
      P_SBLK: begin
        if (field_complete(4)) ph = (tag != 0) ? P_SLEAD : P_SDATA;
      end
      P_SLEAD: begin
        tag--;
        if (tag == 0) ph = P_SDATA;
      end
      P_SDATA: begin
        acc = {acc[23:0], b};
        if (field_complete((int'(depth) + 7) / 8)) sample_out();
      end
      default: ;
    endcase
  endfunction

  // Predict the results of one accepted byte
  function automatic void parse_request(byte_req_t q);
    logic [2:0] st;
    logic [151:0] d;
    if (q.first) parser_clear();
    case (ph)
      P_FORM, P_AIFF: begin
        tag = {tag[23:0], q.b};
        if (field_complete(4)) begin
          if (tag != ((ph == P_FORM) ? TAG_FORM : TAG_AIFF)) begin
            record_error(ST_BAD_TAGS);
            ph = P_DEAD;
          end else begin
            ph = (ph == P_FORM) ? P_FSIZE : P_CKID;
          end
          tag = '0;
        end
      end
      P_FSIZE: if (field_complete(4)) ph = P_AIFF;
      P_CKID: begin
        tag = {tag[23:0], q.b};
        if (field_complete(4)) begin
          ph = P_CKSIZE;
          left = '0;
        end
      end
      P_CKSIZE: begin
        left = {1'b0, left[23:0], q.b};
        if (field_complete(4)) begin
          pad_pend = left[0];
          if (left == 0) chunk_done();
          else chunk_start();
        end
      end
      P_PAD: ph = P_CKID;
      P_DEAD: ;
      default: begin
        chunk_body(q.b);
        left--;
        if (left == 0) chunk_done();
      end
    endcase
    if (q.last) begin
      st = err_code;
      if (ph == P_FORM || ph == P_FSIZE || ph == P_AIFF) st = ST_BAD_TAGS;
      else if (st == ST_OK && frames_seen != frames_claimed) st = ST_MISMATCH;
      d = '0;
      d[148:146] = st;
      push_result(KIND_STATUS, d);
      parser_clear();
    end
  endfunction

  // File building helpers
  function automatic void put8(logic [7:0] v);
    file_bytes.push_back(v);
  endfunction

  function automatic void put16(logic [15:0] v);
    put8(v[15:8]); put8(v[7:0]);
  endfunction

  function automatic void put32(logic [31:0] v);
    put16(v[31:16]); put16(v[15:0]);
  endfunction

  function automatic logic [7:0] edge_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_comm(logic [15:0] ch, logic [31:0] nfr, logic [15:0] dep);
    int extra;
    logic [15:0] ex;
    extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    put32(TAG_COMM);
    put32(32'(18 + extra));
    put16(ch); put32(nfr); put16(dep);
    case ($urandom_range(0, 7))
      0: ex = 16'h8000 | 16'($urandom);
      1: ex = 16'($urandom_range(0, 16382));
      2: ex = 16'h7FFF;
      default: ex = 16'(16383 + $urandom_range(0, 40));
    endcase
    put16(ex);
    put32($urandom); put32($urandom);
    repeat (extra) put8(8'($urandom));
    if (extra % 2 == 1) put8(8'h00);
  endfunction

  // Modes: 0 well-formed, 1 bad FORM, 2 bad AIFF, 3 short COMM, 4 sound
  // with no COMM, 5 unusable format, 6 truncated, 7 noise, 8 cut, no last
  function automatic void build_file(int mode, int dep_in, int ch_in);
    int dep, ch, nf, nb, off, part, ssz, len, cut, usz;
    byte_req_t q;
    file_bytes.delete();
    dep = (dep_in != 0) ? dep_in : $urandom_range(1, 32);
    ch = (ch_in != 0) ? ch_in : $urandom_range(1, 3);
    nf = $urandom_range(0, 4);
    nb = (dep + 7) / 8;
    if (mode == 7) begin
      repeat ($urandom_range(1, 20)) put8(8'($urandom));
    end else begin
      put32((mode == 1) ? 32'($urandom) & 32'hFFFF_FFFE : TAG_FORM);
      put32($urandom);
      put32((mode == 2) ? TAG_AIFF ^ (32'h1 << $urandom_range(0, 31)) : TAG_AIFF);
      if ($urandom_range(0, 2) == 0) begin
        usz = $urandom_range(0, 5);
        put32($urandom); put32(32'(usz));
        repeat (usz) put8(8'($urandom));
        if (usz % 2 == 1) put8(8'($urandom));
      end
      if (mode == 3) begin
        usz = $urandom_range(0, 17);
        put32(TAG_COMM); put32(32'(usz));
        repeat (usz) put8(8'($urandom));
        if (usz % 2 == 1) put8(8'h00);
      end else if (mode == 5) begin
        case ($urandom_range(0, 2))
          0: put_comm(16'(ch), 32'(nf), 16'h0);
          1: put_comm(16'(ch), 32'(nf), 16'($urandom_range(33, 65535)));
          default: put_comm(16'h0, 32'(nf), 16'(dep));
        endcase
      end else if (mode != 4) begin
        if ($urandom_range(0, 5) == 0) put_comm(16'($urandom), $urandom, 16'(dep));
        put_comm(16'(ch), ($urandom_range(0, 4) == 0) ? 32'(nf + $urandom_range(0, 2)) - 1
                                                      : 32'(nf), 16'(dep));
      end
      off = $urandom_range(0, 3);
      part = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if (part >= nb) part = 0;
      ssz = 8 + off + nf * ch * nb + part;
      put32(TAG_SSND); put32(32'(ssz));
      put32(32'(off)); put32($urandom);
      repeat (off) put8(8'($urandom));
      repeat (nf * ch * nb + part) put8(edge_byte());
      if (ssz % 2 == 1) put8(8'h00);
      if ($urandom_range(0, 3) == 0) begin
        // chunk with a huge size: only its opening bytes arrive
        put32($urandom); put32(32'hFFFF_FFFF);
        repeat ($urandom_range(0, 4)) put8(8'($urandom));
      end
    end
    len = file_bytes.size();
    cut = len;
    if (mode == 6 || mode == 8) cut = $urandom_range(1, len);
    for (int i = 0; i < cut; i++) begin
      q.b = file_bytes[i];
      q.first = (i == 0) || ($urandom_range(0, 40) == 0 && mode == 7);
      q.last = (i == cut - 1) && (mode != 8);
      q.hold = 1'b0;
      pending_bytes.push_back(q);
    end
  endfunction

  // Stimulus
  initial begin
    int target;
    int m;
    errors = 0;
    reported = 0;
    done_gen = 1'b0;
    parser_clear();
    // Directed: extremes of depth, pad handling, tag failures, special cases
    build_file(0, 32, 1);
    build_file(0, 8, 2);
    build_file(0, 1, 1);
    build_file(0, 24, 3);
    build_file(1, 0, 0);
    build_file(2, 0, 0);
    build_file(3, 0, 0);
    build_file(4, 0, 0);
    build_file(5, 0, 0);
    build_file(6, 0, 0);
    // Random part, opened by a drain pause
    target = 750;
    m = pending_bytes.size();
    build_file(0, 0, 0);
    while (pending_bytes.size() < target) begin
      case ($urandom_range(0, 19))
        0: build_file(1, 0, 0);
        1: build_file(2, 0, 0);
        2: build_file(3, 0, 0);
        3: build_file(4, 0, 0);
        4: build_file(5, 0, 0);
        5, 6: build_file(6, 0, 0);
        7: build_file(7, 0, 0);
        8: build_file(8, 0, 0);
        default: build_file(0, 0, 0);
      endcase
    end
    pending_bytes[m].hold = 1'b1;
    done_gen = 1'b1;
  end

  // Reset
  initial begin
    rst_n = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Random gap length: mostly short, a few long
  function automatic int gap_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Input driver
  int  in_gap;
  int  sent;
  bit  in_quiet;
  byte_req_t cur;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      in_tlast <= 1'b0;
      in_gap <= 0;
      sent <= 0;
      in_quiet <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (done_gen && pending_bytes.size() != 0 &&
                   !(pending_bytes[0].hold && expected_results.size() != 0)) begin
        cur = pending_bytes.pop_front();
        parse_request(cur);
        in_tvalid <= 1'b1;
        in_tdata <= cur.b;
        in_tuser <= cur.first;
        in_tlast <= cur.last;
        sent <= sent + 1;
        if (sent % 150 == 149) in_quiet <= ~in_quiet;
        in_gap <= gap_len(in_quiet);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result monitor and backpressure
  int  out_gap;
  bit  out_quiet;
  int  got;
  result_exp_t want;
  logic [31:0] want_f;
  logic [31:0] got_f;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap <= 0;
      out_quiet <= 1'b0;
      got <= 0;
    end else begin
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap <= out_gap - 1;
      end else begin
        out_tready <= 1'b1;
        out_gap <= gap_len(out_quiet);
      end
      if (out_tvalid && out_tready) begin
        got <= got + 1;
        if (got % 120 == 119) out_quiet <= ~out_quiet;
        if (expected_results.size() == 0) begin
          errors++;
          if (reported < 10) begin
            reported++;
            $display("unexpected result: kind %0d data %h", out_tuser, out_tdata);
          end
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.kind) begin
            errors++;
            if (reported < 10) begin
              reported++;
              $display("kind mismatch: expected %0d got %0d", want.kind, out_tuser);
            end
          end
          for (int i = 0; i < FLD_N; i++) begin
            want_f = 32'((want.data >> FLD_LO[i]) & ((152'h1 << FLD_W[i]) - 152'h1));
            got_f = 32'((out_tdata >> FLD_LO[i]) & ((152'h1 << FLD_W[i]) - 152'h1));
            if ($isunknown(out_tdata) || got_f !== want_f) begin
              errors++;
              if (reported < 10) begin
                reported++;
                $display("field at bit %0d (kind %0d): expected %h got %h",
                         FLD_LO[i], want.kind, want_f, got_f);
              end
            end
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted byte or taken result
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      watchdog <= 0;
    end else begin
      watchdog <= watchdog + 1;
      if (watchdog >= 5000) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    wait (rst_n === 1'b1 && done_gen);
    wait (pending_bytes.size() == 0 && !in_tvalid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ aiff_stream_parser_unit.f @@
+incdir+hw/rtl
hw/rtl/asp_pkg.sv
hw/rtl/asp_rate.sv
hw/rtl/aiff_stream_parser_unit.sv
tb/aiff_stream_parser_unit_tb.sv
